// ----- rtl/core/ogr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ogr_pkg
// shared types, command codes, register indexes and trig / percent tables
// for the occupancy grid ray update core
// ----------------------------------------------------------------------------
package ogr_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_POSE  = 2'd0,
        CMD_BEAM  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_SPARE = 2'd3
    } t_cmd;

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_ANGLE_START  = 3'd0,
        REG_ANGLE_STEP   = 3'd1,
        REG_RANGE_MIN    = 3'd2,
        REG_RANGE_MAX    = 3'd3,
        REG_UPDATE_LIMIT = 3'd4,
        REG_FREE_LO      = 3'd5,
        REG_OCC_LO       = 3'd6,
        REG_UNKNOWN_LO   = 3'd7
    } t_reg_idx;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CLEAR  = 8'b0000_0010,
        ST_ANGLE  = 8'b0000_0100,
        ST_TRIG   = 8'b0000_1000,
        ST_INIT   = 8'b0001_0000,
        ST_MARCH  = 8'b0010_0000,
        ST_ENDPT  = 8'b0100_0000,
        ST_RESULT = 8'b1000_0000
    } t_state;

    localparam int RANGE_W = 18;
    localparam int ANGLE_W = 16;
    localparam int POSE_W  = 17;
    localparam int LO_CFG_W = 16;
    localparam int RC_IN_W = 9;
    localparam int PADDR_W = 5;

    localparam logic [14:0] SIN_TAB [0:16] = '{
        15'd0, 15'd1606, 15'd3196, 15'd4756, 15'd6270, 15'd7723, 15'd9102,
        15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449, 15'd15137,
        15'd15679, 15'd16069, 15'd16305, 15'd16384
    };

    // log-odds thresholds for 51..100 percent, Q8.8
    localparam logic [10:0] PCT_THR [0:49] = '{
        11'd5, 11'd15, 11'd26, 11'd36, 11'd46, 11'd57, 11'd67, 11'd77, 11'd88,
        11'd98, 11'd109, 11'd120, 11'd131, 11'd142, 11'd153, 11'd164, 11'd176,
        11'd187, 11'd199, 11'd211, 11'd223, 11'd235, 11'd248, 11'd261, 11'd274,
        11'd288, 11'd302, 11'd317, 11'd332, 11'd347, 11'd363, 11'd380, 11'd397,
        11'd415, 11'd434, 11'd454, 11'd476, 11'd498, 11'd522, 11'd549, 11'd577,
        11'd608, 11'd643, 11'd683, 11'd728, 11'd782, 11'd849, 11'd938, 11'd1071,
        11'd1355
    };

    // sine over a quarter wave with linear interpolation, u in 0..16384
    function automatic logic [14:0] sin_quarter(input logic [14:0] u);
        logic [4:0]  idx;
        logic [9:0]  frac;
        logic [10:0] diff;
        logic [20:0] prod;
        idx  = {1'b0, u[13:10]};
        frac = u[9:0];
        diff = 11'(SIN_TAB[idx + 5'd1] - SIN_TAB[idx]);
        prod = diff * frac;
        if (u[14]) begin
            return 15'd16384;
        end
        return SIN_TAB[idx] + 15'(prod[20:10]);
    endfunction

    // Q14 sine of a 16-bit binary angle
    function automatic logic signed [15:0] sin_q14(input logic [15:0] a);
        logic [14:0] u;
        logic [14:0] mag;
        u   = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        mag = sin_quarter(u);
        return a[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ogr_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ogr_in_if
// command channel: pose, beam and read transactions
// ----------------------------------------------------------------------------
interface ogr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic signed [16:0] pose_x;
    logic signed [16:0] pose_y;
    logic [15:0] pose_heading;
    logic [9:0]  beam_index;
    logic [17:0] beam_range;
    logic [8:0]  cell_row;
    logic [8:0]  cell_col;

    modport source (output valid, cmd, pose_x, pose_y, pose_heading, beam_index,
                    beam_range, cell_row, cell_col, input ready);
    modport sink   (input valid, cmd, pose_x, pose_y, pose_heading, beam_index,
                    beam_range, cell_row, cell_col, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ogr_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ogr_out_if
// result channel: cell occupancy percent
// ----------------------------------------------------------------------------
interface ogr_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] cell_value;

    modport source (output valid, cell_value, input ready);
    modport sink   (input valid, cell_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/occupancy_grid_ray_update_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_core
// log-odds occupancy grid held in one synchronous memory, updated by
// marching each lidar beam cell by cell with read-modify-write
// ----------------------------------------------------------------------------
// channel   dir  handshake          carries
// i_in      in   valid / ready      cmd, pose, beam index/range, cell row/col
// o_out     out  valid / ready      cell_value (percent or -1)
// apb       in   psel/penable/pready register writes and reads
//
// after reset a clearing pass writes zero to all MAP_SIDE*MAP_SIDE cells,
// one per cycle; no transaction is taken meanwhile. pose and spare commands
// are handled in the idle state. a beam goes from the accepting idle state
// through the angle, trig and init setup states, then marches one cell per
// cycle (grid memory port, one read-modify-write per cell) until a march
// cycle finds the end, then the endpoint state. a read goes to the result
// state, which waits while the result register holds and o_out.ready is low.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update_core #(
    parameter int MAP_SIDE      = 512,
    parameter int LOGODDS_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ogr_in_if.sink    i_in,
    ogr_out_if.source o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int LW     = LOGODDS_WIDTH;
    localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RC_W   = $clog2(MAP_SIDE);
    localparam int SUM_W  = ((LW > 16) ? LW : 16) + 1;
    localparam int ACC_W  = 42;
    localparam int CELL_W = ACC_W - 22;
    localparam int R_W    = 20;
    localparam longint SAT_HI = (64'sd1 <<< (LW - 1)) - 64'sd1;
    localparam logic signed [SUM_W-1:0] SAT_HI_S = SUM_W'(SAT_HI);
    localparam logic signed [SUM_W-1:0] SAT_LO_S = -SAT_HI_S - SUM_W'(1);
    localparam logic signed [ACC_W-1:0] ORIGIN = ACC_W'((MAP_SIDE / 2) * 256);

    function automatic logic [LW-1:0] sat_lo(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI_S) begin
            return LW'(SAT_HI_S);
        end
        if (v < SAT_LO_S) begin
            return LW'(SAT_LO_S);
        end
        return LW'(v);
    endfunction

    // configuration registers
    logic [15:0] r_angle_start, r_angle_step;
    logic [17:0] r_range_min, r_range_max, r_update_limit;
    logic signed [15:0] r_free_lo, r_occ_lo, r_unknown_lo;

    // robot pose
    logic signed [16:0] r_robot_x, r_robot_y;
    logic [15:0] r_robot_heading;

    ogr_pkg::t_state r_state, n_state;

    // beam working set
    logic [9:0]  r_beam_idx;
    logic [17:0] r_rng;
    logic [15:0] r_theta;
    logic signed [15:0] r_cos, r_sin;
    logic signed [ACC_W-1:0] r_acc_x, r_acc_y;
    logic [R_W-1:0] r_r;
    logic r_visited, r_stopped, r_last_onmap;
    logic [ADDR_W-1:0] r_last_addr;

    // update stage (second half of the read-modify-write)
    logic r_s1_valid;
    logic [ADDR_W-1:0] r_s1_addr;
    logic signed [15:0] r_s1_delta;
    logic r_wr_valid;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [LW-1:0] r_wr_data;

    // read command / result
    logic r_rd_offmap;
    logic r_out_valid;
    logic signed [7:0] r_out_value;
    logic [ADDR_W-1:0] r_clr_addr;

    // grid memory
    logic [LW-1:0] mem [DEPTH];
    logic [LW-1:0] mem_rd;
    logic mem_we, mem_re;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [LW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_rd <= mem[mem_ra];
        end
    end

    // apb
    logic cfg_wr;
    logic [2:0] cfg_idx;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        unique case (ogr_pkg::t_reg_idx'(cfg_idx))
            ogr_pkg::REG_ANGLE_START:  prdata = 32'(r_angle_start);
            ogr_pkg::REG_ANGLE_STEP:   prdata = 32'(r_angle_step);
            ogr_pkg::REG_RANGE_MIN:    prdata = 32'(r_range_min);
            ogr_pkg::REG_RANGE_MAX:    prdata = 32'(r_range_max);
            ogr_pkg::REG_UPDATE_LIMIT: prdata = 32'(r_update_limit);
            ogr_pkg::REG_FREE_LO:      prdata = 32'(unsigned'(r_free_lo));
            ogr_pkg::REG_OCC_LO:       prdata = 32'(unsigned'(r_occ_lo));
            ogr_pkg::REG_UNKNOWN_LO:   prdata = 32'(unsigned'(r_unknown_lo));
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start  <= 16'd0;
            r_angle_step   <= 16'd0;
            r_range_min    <= 18'd0;
            r_range_max    <= 18'd262143;
            r_update_limit <= 18'd51200;
            r_free_lo      <= -16'sd104;
            r_occ_lo       <= 16'sd104;
            r_unknown_lo   <= 16'sd0;
        end else if (cfg_wr) begin
            unique case (ogr_pkg::t_reg_idx'(cfg_idx))
                ogr_pkg::REG_ANGLE_START:  r_angle_start  <= pwdata[15:0];
                ogr_pkg::REG_ANGLE_STEP:   r_angle_step   <= pwdata[15:0];
                ogr_pkg::REG_RANGE_MIN:    r_range_min    <= pwdata[17:0];
                ogr_pkg::REG_RANGE_MAX:    r_range_max    <= pwdata[17:0];
                ogr_pkg::REG_UPDATE_LIMIT: r_update_limit <= pwdata[17:0];
                ogr_pkg::REG_FREE_LO:      r_free_lo      <= $signed(pwdata[15:0]);
                ogr_pkg::REG_OCC_LO:       r_occ_lo       <= $signed(pwdata[15:0]);
                ogr_pkg::REG_UNKNOWN_LO:   r_unknown_lo   <= $signed(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    // input handshake: only the idle state takes a transaction
    logic in_acc;
    assign i_in.ready = (r_state == ogr_pkg::ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // march step: cell coordinates are floor(acc / 2^22)
    logic signed [CELL_W-1:0] step_row, step_col;
    logic step_onmap, step_go, step_stop, march_end;
    logic [ADDR_W-1:0] step_addr;
    logic [R_W-1:0] rng_ext;
    logic signed [15:0] step_delta;

    assign step_row   = r_acc_y[ACC_W-1:22];
    assign step_col   = r_acc_x[ACC_W-1:22];
    assign step_onmap = !step_row[CELL_W-1] && !step_col[CELL_W-1]
                        && (step_row < CELL_W'(MAP_SIDE)) && (step_col < CELL_W'(MAP_SIDE));
    assign step_addr  = ADDR_W'(ADDR_W'(step_row[RC_W-1:0]) * ADDR_W'(MAP_SIDE))
                        + ADDR_W'(step_col[RC_W-1:0]);
    assign rng_ext    = R_W'(r_rng);
    assign march_end  = !(r_r < rng_ext + R_W'(512));
    assign step_stop  = !march_end && (r_r > R_W'(r_update_limit));
    assign step_go    = (r_state == ogr_pkg::ST_MARCH) && !march_end && !step_stop;

    always_comb begin
        priority if (r_r < rng_ext + R_W'(128)) begin
            step_delta = r_free_lo;
        end else if (r_r > rng_ext + R_W'(128)) begin
            step_delta = r_unknown_lo;
        end else begin
            step_delta = r_occ_lo;
        end
    end

    // update stage with forwarding of last cycle's write to the same cell
    logic [LW-1:0] s1_cell;
    logic [LW-1:0] s1_new;
    assign s1_cell = (r_wr_valid && r_wr_addr == r_s1_addr) ? r_wr_data : mem_rd;
    assign s1_new  = sat_lo(SUM_W'($signed(s1_cell)) + SUM_W'(r_s1_delta));

    // read command address
    logic rd_in_offmap;
    logic [ADDR_W-1:0] rd_in_addr;
    assign rd_in_offmap = (32'(i_in.cell_row) >= 32'(MAP_SIDE))
                          || (32'(i_in.cell_col) >= 32'(MAP_SIDE));
    assign rd_in_addr   = ADDR_W'(ADDR_W'(i_in.cell_row) * ADDR_W'(MAP_SIDE))
                          + ADDR_W'(i_in.cell_col);

    // percent conversion from the read cell
    logic signed [SUM_W-1:0] rd_cell_s;
    logic [SUM_W-1:0] rd_abs;
    logic [6:0] pct_cnt;
    logic [6:0] pct_p;
    logic signed [7:0] pct_val;
    assign rd_cell_s = SUM_W'($signed(mem_rd));
    assign rd_abs    = rd_cell_s[SUM_W-1] ? SUM_W'(-rd_cell_s) : SUM_W'(rd_cell_s);

    always_comb begin
        pct_cnt = 7'd0;
        for (int i = 0; i < 50; i++) begin
            if (33'(rd_abs) >= 33'(ogr_pkg::PCT_THR[i])) begin
                pct_cnt = pct_cnt + 7'd1;
            end
        end
        pct_p = 7'd50 + pct_cnt;
        if (r_rd_offmap || rd_cell_s == SUM_W'(r_unknown_lo)) begin
            pct_val = -8'sd1;
        end else if (rd_cell_s[SUM_W-1]) begin
            pct_val = $signed(8'(7'd100 - pct_p));
        end else begin
            pct_val = $signed(8'(pct_p));
        end
    end

    logic out_free;
    assign out_free     = !r_out_valid || o_out.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.cell_value = r_out_value;

    // memory port steering
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_s1_addr;
        mem_wd = s1_new;
        mem_re = 1'b0;
        mem_ra = step_addr;
        if (r_state == ogr_pkg::ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else if (r_state == ogr_pkg::ST_ENDPT) begin
            mem_we = !r_stopped && r_visited && r_last_onmap;
            mem_wa = r_last_addr;
            mem_wd = sat_lo(SUM_W'(r_occ_lo));
        end else begin
            mem_we = r_s1_valid;
        end
        if (step_go && step_onmap) begin
            mem_re = 1'b1;
        end else if (in_acc && i_in.cmd == ogr_pkg::CMD_READ) begin
            mem_re = 1'b1;
            mem_ra = rd_in_addr;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ogr_pkg::ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ogr_pkg::ST_IDLE;
                end
            end
            ogr_pkg::ST_IDLE: begin
                if (in_acc && i_in.cmd == ogr_pkg::CMD_BEAM) begin
                    n_state = ogr_pkg::ST_ANGLE;
                end else if (in_acc && i_in.cmd == ogr_pkg::CMD_READ) begin
                    n_state = ogr_pkg::ST_RESULT;
                end
            end
            ogr_pkg::ST_ANGLE:  n_state = ogr_pkg::ST_TRIG;
            ogr_pkg::ST_TRIG:   n_state = ogr_pkg::ST_INIT;
            ogr_pkg::ST_INIT:   n_state = ogr_pkg::ST_MARCH;
            ogr_pkg::ST_MARCH: begin
                if (march_end || step_stop) begin
                    n_state = ogr_pkg::ST_ENDPT;
                end
            end
            ogr_pkg::ST_ENDPT:  n_state = ogr_pkg::ST_IDLE;
            ogr_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = ogr_pkg::ST_IDLE;
                end
            end
            default: n_state = ogr_pkg::ST_IDLE;
        endcase
    end

    logic signed [34:0] init_mx, init_my;
    assign init_mx = $signed({1'b0, r_range_min}) * r_cos;
    assign init_my = $signed({1'b0, r_range_min}) * r_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ogr_pkg::ST_CLEAR;
            r_clr_addr      <= '0;
            r_s1_valid      <= 1'b0;
            r_wr_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_visited       <= 1'b0;
            r_stopped       <= 1'b0;
            r_robot_x       <= '0;
            r_robot_y       <= '0;
            r_robot_heading <= '0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= step_go && step_onmap;
            r_wr_valid <= r_s1_valid && (r_state == ogr_pkg::ST_MARCH
                                         || r_state == ogr_pkg::ST_ENDPT);
            if (r_state == ogr_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (in_acc && i_in.cmd == ogr_pkg::CMD_POSE) begin
                r_robot_x       <= i_in.pose_x;
                r_robot_y       <= i_in.pose_y;
                r_robot_heading <= i_in.pose_heading;
            end
            if (r_state == ogr_pkg::ST_INIT) begin
                r_visited <= 1'b0;
                r_stopped <= 1'b0;
            end
            if (step_go) begin
                r_visited <= 1'b1;
            end
            if (step_stop && r_state == ogr_pkg::ST_MARCH) begin
                r_stopped <= 1'b1;
            end
            if (r_state == ogr_pkg::ST_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_beam_idx  <= i_in.beam_index;
            r_rd_offmap <= rd_in_offmap;
            if (i_in.beam_range <= r_range_min || i_in.beam_range >= r_range_max) begin
                r_rng <= r_range_max;
            end else begin
                r_rng <= i_in.beam_range;
            end
        end
        if (r_state == ogr_pkg::ST_ANGLE) begin
            r_theta <= 16'(r_angle_start + 16'(r_angle_step * r_beam_idx) + r_robot_heading);
        end
        if (r_state == ogr_pkg::ST_TRIG) begin
            r_sin <= ogr_pkg::sin_q14(r_theta);
            r_cos <= ogr_pkg::sin_q14(r_theta + 16'd16384);
        end
        if (r_state == ogr_pkg::ST_INIT) begin
            r_acc_x <= ((ORIGIN + ACC_W'(r_robot_x)) <<< 14) + ACC_W'(init_mx);
            r_acc_y <= ((ORIGIN + ACC_W'(r_robot_y)) <<< 14) + ACC_W'(init_my);
            r_r     <= R_W'(r_range_min);
        end
        if (step_go) begin
            r_acc_x      <= r_acc_x + (ACC_W'(r_cos) <<< 8);
            r_acc_y      <= r_acc_y + (ACC_W'(r_sin) <<< 8);
            r_r          <= r_r + R_W'(256);
            r_last_onmap <= step_onmap;
            r_last_addr  <= step_addr;
            r_s1_addr    <= step_addr;
            r_s1_delta   <= step_delta;
        end
        if (r_s1_valid) begin
            r_wr_addr <= r_s1_addr;
            r_wr_data <= s1_new;
        end
        if (r_state == ogr_pkg::ST_RESULT && out_free) begin
            r_out_value <= pct_val;
        end
    end

`ifndef SYNTHESIS
    // update stage only follows a march cycle
    a_s1_from_march: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(r_state == ogr_pkg::ST_MARCH))
        else $error("update stage valid outside march");

    // endpoint write never collides with a pending cell update
    a_endpt_no_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ogr_pkg::ST_ENDPT) |=> !r_s1_valid)
        else $error("cell update pending after endpoint");

    // nothing is taken while the grid is being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ogr_pkg::ST_CLEAR) |-> !i_in.ready && !r_s1_valid)
        else $error("transaction during clearing pass");

    // a result is loaded only from the result state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ogr_pkg::ST_RESULT))
        else $error("result without read command");
`endif

endmodule
`default_nettype wire

// ----- sim/occupancy_grid_ray_update_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_core_tb
// self-checking bench for the occupancy grid ray update core: pose, beam and
// read transactions go in with random gaps, results come out under random
// back-pressure. A local grid model predicts every cell percent. Register
// settings are changed between phases, including their extremes.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update_core_tb;

    localparam int SIDE = 512;

    typedef struct {
        ogr_pkg::t_cmd      cmd;
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic [15:0]        hd;
        logic [9:0]         bidx;
        logic [17:0]        brange;
        logic [8:0]         row;
        logic [8:0]         col;
    } cmd_item_t;

    // quarter-wave sine in Q14 and percent thresholds in Q8.8
    localparam longint QSIN [0:16] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394,
        11585, 12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};
    localparam longint PCT_STEP [0:49] = '{5, 15, 26, 36, 46, 57, 67, 77, 88, 98,
        109, 120, 131, 142, 153, 164, 176, 187, 199, 211, 223, 235, 248, 261, 274,
        288, 302, 317, 332, 347, 363, 380, 397, 415, 434, 454, 476, 498, 522, 549,
        577, 608, 643, 683, 728, 782, 849, 938, 1071, 1355};

    logic i_clk;
    logic i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ogr_in_if  in_if ();
    ogr_out_if out_if ();

    occupancy_grid_ray_update_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state: grid, pose and register copies
    shortint grid_lo [0:SIDE*SIDE-1];
    longint  robot_px, robot_py;
    logic [15:0] robot_hd;
    logic [15:0] ang_start, ang_step;
    longint  rng_min, rng_max, upd_limit, lo_free, lo_occ, lo_unknown;

    cmd_item_t           cmd_queue [$];
    logic signed [7:0]   percent_due [$];
    int                  errors;
    bit                  gaps_on;
    int                  send_gap;
    int                  recv_stall;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // queue helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input cmd_item_t it);
        cmd_queue.insert(cmd_queue.size(), it);
    endtask

    task automatic queue_percent(input logic signed [7:0] v);
        percent_due.insert(percent_due.size(), v);
    endtask

    // ------------------------------------------------------------------------
    // model arithmetic
    // ------------------------------------------------------------------------
    function automatic longint quarter_sine(input longint u);
        longint idx;
        longint frac;
        if (u >= 16384) begin
            return 16384;
        end
        idx  = u >> 10;
        frac = u & 1023;
        return QSIN[idx] + (((QSIN[idx+1] - QSIN[idx]) * frac) >> 10);
    endfunction

    function automatic longint sine_q14(input logic [15:0] a);
        longint u;
        u = longint'(a[13:0]);
        case (a[15:14])
            2'd0: return quarter_sine(u);
            2'd1: return quarter_sine(16384 - u);
            2'd2: return -quarter_sine(u);
            default: return -quarter_sine(16384 - u);
        endcase
    endfunction

    function automatic shortint clip_lo(input longint v);
        if (v > 32767) begin
            return 16'sd32767;
        end
        if (v < -32768) begin
            return -16'sd32768;
        end
        return shortint'(v);
    endfunction

    function automatic bit on_map(input longint row, input longint col);
        return row >= 0 && row < SIDE && col >= 0 && col < SIDE;
    endfunction

    function automatic logic signed [7:0] lo_to_percent(input longint l);
        longint a;
        int     p;
        a = (l < 0) ? -l : l;
        p = 50;
        for (int i = 0; i < 50; i++) begin
            if (a >= PCT_STEP[i]) begin
                p = 51 + i;
            end
        end
        return 8'(l < 0 ? 100 - p : p);
    endfunction

    // one beam: march from minimum range, one cell per step
    task automatic march_beam(input logic [9:0] bidx, input logic [17:0] brange);
        longint rng, cs, sn, bx, by, r, row, col, last_row, last_col, delta;
        logic [15:0] theta;
        bit seen;
        bit halted;
        rng      = longint'(brange);
        seen     = 1'b0;
        halted   = 1'b0;
        last_row = 0;
        last_col = 0;
        if (rng <= rng_min || rng >= rng_max) begin
            rng = rng_max;
        end
        theta = ang_start + ang_step * bidx + robot_hd;
        cs    = sine_q14(theta + 16'h4000);
        sn    = sine_q14(theta);
        bx    = (longint'(SIDE / 2) * 256 + robot_px) * 16384;
        by    = (longint'(SIDE / 2) * 256 + robot_py) * 16384;
        for (r = rng_min; r < rng + 512; r += 256) begin
            if (r > upd_limit) begin
                halted = 1'b1;
                break;
            end
            col      = (bx + r * cs) >>> 22;
            row      = (by + r * sn) >>> 22;
            seen     = 1'b1;
            last_row = row;
            last_col = col;
            if (on_map(row, col)) begin
                if (r < rng + 128) begin
                    delta = lo_free;
                end else if (r > rng + 128) begin
                    delta = lo_unknown;
                end else begin
                    delta = lo_occ;
                end
                grid_lo[row*SIDE+col] = clip_lo(longint'(grid_lo[row*SIDE+col]) + delta);
            end
        end
        // forced endpoint unless the update limit cut the ray short
        if (!halted && seen && on_map(last_row, last_col)) begin
            grid_lo[last_row*SIDE+last_col] = clip_lo(lo_occ);
        end
    endtask

    task automatic apply_command(input cmd_item_t it);
        longint l;
        case (it.cmd)
            ogr_pkg::CMD_POSE: begin
                robot_px = longint'(it.px);
                robot_py = longint'(it.py);
                robot_hd = it.hd;
            end
            ogr_pkg::CMD_BEAM: march_beam(it.bidx, it.brange);
            ogr_pkg::CMD_READ: begin
                l = longint'(grid_lo[int'(it.row)*SIDE+int'(it.col)]);
                queue_percent(l == lo_unknown ? -8'sd1 : lo_to_percent(l));
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic cmd_item_t blank_item(input ogr_pkg::t_cmd c);
        cmd_item_t it;
        it.cmd    = c;
        it.px     = 17'($urandom);
        it.py     = 17'($urandom);
        it.hd     = 16'($urandom);
        it.bidx   = 10'($urandom);
        it.brange = 18'($urandom);
        it.row    = 9'($urandom);
        it.col    = 9'($urandom);
        return it;
    endfunction

    function automatic cmd_item_t pose_item(input int x, input int y, input int h);
        cmd_item_t it;
        it    = blank_item(ogr_pkg::CMD_POSE);
        it.px = 17'(x);
        it.py = 17'(y);
        it.hd = 16'(h);
        return it;
    endfunction

    function automatic cmd_item_t beam_item(input int b, input int r);
        cmd_item_t it;
        it        = blank_item(ogr_pkg::CMD_BEAM);
        it.bidx   = 10'(b);
        it.brange = 18'(r);
        return it;
    endfunction

    function automatic cmd_item_t read_item(input int row, input int col);
        cmd_item_t it;
        it     = blank_item(ogr_pkg::CMD_READ);
        it.row = 9'(row);
        it.col = 9'(col);
        return it;
    endfunction

    // mostly poses near the centre, short beams and reads where beams land
    function automatic cmd_item_t random_item();
        int k;
        k = $urandom_range(0, 99);
        if (k < 20) begin
            if ($urandom_range(0, 4) == 0) begin
                return blank_item(ogr_pkg::CMD_POSE);
            end
            return pose_item($urandom_range(0, 20480) - 10240,
                             $urandom_range(0, 20480) - 10240, $urandom);
        end else if (k < 60) begin
            if ($urandom_range(0, 5) == 0) begin
                return blank_item(ogr_pkg::CMD_BEAM);
            end
            return beam_item($urandom, $urandom_range(0, 50 * 256));
        end else if (k < 95) begin
            if ($urandom_range(0, 5) == 0) begin
                return blank_item(ogr_pkg::CMD_READ);
            end
            return read_item(216 + $urandom_range(0, 80), 216 + $urandom_range(0, 80));
        end
        return blank_item(ogr_pkg::CMD_SPARE);
    endfunction

    // ------------------------------------------------------------------------
    // command driver: next queued item after a drawn gap
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap    <= 0;
        end else if (in_if.valid && !in_if.ready) begin
            // hold the offered transaction
        end else if (send_gap != 0) begin
            in_if.valid <= 1'b0;
            send_gap    <= send_gap - 1;
        end else if (cmd_queue.size() != 0) begin
            cmd_item_t it;
            it = cmd_queue.pop_front();
            in_if.valid        <= 1'b1;
            in_if.cmd          <= it.cmd;
            in_if.pose_x       <= it.px;
            in_if.pose_y       <= it.py;
            in_if.pose_heading <= it.hd;
            in_if.beam_index   <= it.bidx;
            in_if.beam_range   <= it.brange;
            in_if.cell_row     <= it.row;
            in_if.cell_col     <= it.col;
            send_gap           <= gaps_on ? $urandom_range(0, 18) : 0;
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // accepted commands feed the model
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            cmd_item_t it;
            it.cmd    = ogr_pkg::t_cmd'(in_if.cmd);
            it.px     = in_if.pose_x;
            it.py     = in_if.pose_y;
            it.hd     = in_if.pose_heading;
            it.bidx   = in_if.beam_index;
            it.brange = in_if.beam_range;
            it.row    = in_if.cell_row;
            it.col    = in_if.cell_col;
            apply_command(it);
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_stall   <= 0;
        end else if (out_if.valid && out_if.ready) begin
            int n;
            n = gaps_on ? $urandom_range(0, 18) : 0;
            if (percent_due.size() == 0) begin
                $display("%0t unexpected cell_value: expected none actual %0d",
                         $time, out_if.cell_value);
                errors++;
            end else begin
                logic signed [7:0] want;
                want = percent_due.pop_front();
                if (want !== out_if.cell_value) begin
                    $display("%0t cell_value mismatch: expected %0d actual %0d",
                             $time, want, out_if.cell_value);
                    errors++;
                end
            end
            out_if.ready <= (n == 0);
            recv_stall   <= n;
        end else if (recv_stall != 0) begin
            out_if.ready <= (recv_stall == 1);
            recv_stall   <= recv_stall - 1;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // register access and phase control
    // ------------------------------------------------------------------------
    task automatic write_reg(input ogr_pkg::t_reg_idx idx, input logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'({idx, 2'b00});
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ogr_pkg::REG_ANGLE_START:  ang_start  = v[15:0];
            ogr_pkg::REG_ANGLE_STEP:   ang_step   = v[15:0];
            ogr_pkg::REG_RANGE_MIN:    rng_min    = longint'(v[17:0]);
            ogr_pkg::REG_RANGE_MAX:    rng_max    = longint'(v[17:0]);
            ogr_pkg::REG_UPDATE_LIMIT: upd_limit  = longint'(v[17:0]);
            ogr_pkg::REG_FREE_LO:      lo_free    = longint'($signed(v[15:0]));
            ogr_pkg::REG_OCC_LO:       lo_occ     = longint'($signed(v[15:0]));
            default:                   lo_unknown = longint'($signed(v[15:0]));
        endcase
    endtask

    task automatic set_all(input logic [31:0] a0, input logic [31:0] a1,
                           input logic [31:0] a2, input logic [31:0] a3,
                           input logic [31:0] a4, input logic [31:0] a5,
                           input logic [31:0] a6, input logic [31:0] a7);
        write_reg(ogr_pkg::REG_ANGLE_START, a0);
        write_reg(ogr_pkg::REG_ANGLE_STEP, a1);
        write_reg(ogr_pkg::REG_RANGE_MIN, a2);
        write_reg(ogr_pkg::REG_RANGE_MAX, a3);
        write_reg(ogr_pkg::REG_UPDATE_LIMIT, a4);
        write_reg(ogr_pkg::REG_FREE_LO, a5);
        write_reg(ogr_pkg::REG_OCC_LO, a6);
        write_reg(ogr_pkg::REG_UNKNOWN_LO, a7);
    endtask

    // drain everything, then leave room for a beam still marching
    task automatic drain();
        while (cmd_queue.size() != 0 || in_if.valid || percent_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (1200) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n);
        repeat (n) queue_cmd(random_item());
        drain();
    endtask

    initial begin
        errors      = 0;
        gaps_on     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_if.valid = 1'b0;
        in_if.cmd   = ogr_pkg::CMD_POSE;
        in_if.pose_x = '0;
        in_if.pose_y = '0;
        in_if.pose_heading = '0;
        in_if.beam_index   = '0;
        in_if.beam_range   = '0;
        in_if.cell_row     = '0;
        in_if.cell_col     = '0;
        out_if.ready = 1'b0;
        robot_px   = 0;
        robot_py   = 0;
        robot_hd   = '0;
        ang_start  = '0;
        ang_step   = '0;
        rng_min    = 0;
        rng_max    = 262143;
        upd_limit  = 51200;
        lo_free    = -104;
        lo_occ     = 104;
        lo_unknown = 0;
        i_rst_n    = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // clearing pass: the command channel stays closed until it ends
        while (!in_if.ready) begin
            @(posedge i_clk);
        end

        // directed part under reset settings
        gaps_on = 1'b1;
        queue_cmd(read_item(0, 0));               // untouched cell is unknown
        queue_cmd(read_item(511, 511));
        queue_cmd(pose_item(0, 0, 0));
        queue_cmd(beam_item(0, 5 * 256));         // ray along +x from centre
        queue_cmd(read_item(256, 256));
        queue_cmd(read_item(256, 259));
        queue_cmd(read_item(256, 261));           // cell at the beam range is marked free
        queue_cmd(beam_item(1023, 0));            // range below minimum -> max
        queue_cmd(read_item(256, 300));
        queue_cmd(read_item(256, 456));           // last cell within the update limit
        queue_cmd(pose_item(65535, -65536, 16'hFFFF)); // pose at map edge
        queue_cmd(beam_item(0, 10 * 256));        // mostly off map
        queue_cmd(read_item(0, 511));
        queue_cmd(pose_item(-65536, 65535, 16'h4000));
        queue_cmd(beam_item(1023, 262143));
        queue_cmd(blank_item(ogr_pkg::CMD_SPARE)); // spare command: no result
        queue_cmd(pose_item(256, -256, 16'h8000));
        queue_cmd(beam_item(512, 3 * 256 + 128));
        queue_cmd(read_item(255, 254));
        queue_cmd(read_item(255, 253));
        drain();

        // ordinary settings, gaps on both sides
        set_all(0, 64, 0, 30 * 256, 51200, 32'hFFFF_FF98, 104, 0);
        random_phase(140);

        // extremes of the log-odds values drive cells into saturation
        gaps_on = 1'b0;
        set_all(16'hFFFF, 16'hFFFF, 3 * 256 + 17, 262143, 40 * 256,
                16'h8000, 16'h7FFF, 16'h8000);
        random_phase(140);

        // zero max range and zero update limit: every ray stops early
        gaps_on = 1'b1;
        set_all(16'h4000, 16'h0333, 0, 0, 0, 1, 16'hFFFF, 16'h7FFF);
        random_phase(140);

        // long rays out to the full range, only a few items
        set_all(16'h1234, 16'h0101, 200 * 256, 262143, 262143, 16'hFF00, 16'h0300, 0);
        random_phase(30);

        // random settings with bounded march length
        set_all($urandom, $urandom, $urandom_range(0, 10 * 256),
                $urandom_range(0, 60 * 256), $urandom_range(0, 70 * 256),
                $urandom, $urandom, $urandom);
        random_phase(90);
        gaps_on = 1'b0;
        random_phase(90);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
